@@ rtl/multi_source_bark_bite_watchdog_assert.svh @@
// Assertion macros used by the checker file.
`ifndef MULTI_SOURCE_BARK_BITE_WATCHDOG_ASSERT_SVH
`define MULTI_SOURCE_BARK_BITE_WATCHDOG_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MBBW_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("watchdog assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MBBW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("watchdog assertion failed");

`endif

@@ rtl/mbbw_pkg.sv @@
package mbbw_pkg;

	localparam int NUM_SOURCES_DEF = 7;
	localparam int COUNT_WIDTH_DEF = 16;

	localparam int NUM_REGS  = 7;
	localparam int REG_W     = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CMD_W     = 3;
	localparam int SRC_W     = 3;
	localparam int KIND_W    = 2;
	localparam int OUT_REM_W = 16;

	localparam int TRANSPORT_SRC = 4;

	localparam logic [CMD_W-1:0] CMD_START  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_STOP   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_PAUSE  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_RESUME = 3'd3;
	localparam logic [CMD_W-1:0] CMD_TICK   = 3'd4;

	localparam logic [KIND_W-1:0] KIND_BARK   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_BITE   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_NOTICE = 2'd2;

	localparam logic [REG_W-1:0] REG_RESET [NUM_REGS] = '{
		16'd5, 16'd5, 16'd10, 16'd5, 16'd20, 16'd20, 16'd20
	};

	// Operation on the channel store
	typedef enum logic [1:0] {
		CH_NONE,
		CH_START,
		CH_STOP,
		CH_UPDATE
	} chan_op_t;

	// Verdict of the shared countdown unit for one channel
	typedef struct packed {
		logic bite;
		logic notice;
		logic bark;
	} dec_res_t;

endpackage

@@ rtl/multi_source_bark_bite_watchdog.sv @@
// Start, stop, pause and resume words are handled in idle; ready stays high after them.
// A tick word (not paused) scans one channel per cycle through one shared
// countdown unit, unless the output is full while an event is already held;
// after the last channel it enters a flush state if it raised events, and
// the final event word of the tick leaves from that flush state.
// Reset (arst_n low, asynchronous) clears all channels and pause, reloads timeouts.
module multi_source_bark_bite_watchdog #(
	parameter int NUM_SOURCES = mbbw_pkg::NUM_SOURCES_DEF,
	parameter int COUNT_WIDTH = mbbw_pkg::COUNT_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration write port
	input  logic                             cfg_wr_en,
	input  logic [mbbw_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [mbbw_pkg::REG_W-1:0]       cfg_wdata,
	// command words
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [mbbw_pkg::CMD_W-1:0]       command,
	input  logic [mbbw_pkg::SRC_W-1:0]       source,
	// event words
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [mbbw_pkg::SRC_W-1:0]       event_source,
	output logic [mbbw_pkg::KIND_W-1:0]      event_kind,
	output logic [mbbw_pkg::OUT_REM_W-1:0]   remaining_ticks,
	output logic                             last_event
);
	import mbbw_pkg::*;

	localparam int IDX_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SOURCES - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	state_t            state_q;
	logic [IDX_W-1:0]  idx_q;
	logic              paused_q;

	// One event is held back so that the final one of a tick can be marked.
	logic                 pend_valid_q;
	logic [SRC_W-1:0]     pend_src_q;
	logic [KIND_W-1:0]    pend_kind_q;
	logic [OUT_REM_W-1:0] pend_rem_q;

	logic                 out_valid_q;
	logic [SRC_W-1:0]     out_src_q;
	logic [KIND_W-1:0]    out_kind_q;
	logic [OUT_REM_W-1:0] out_rem_q;
	logic                 out_last_q;

	// store and shared unit hookup
	chan_op_t               ch_op;
	logic [IDX_W-1:0]       ch_addr;
	logic                   rd_active;
	logic [COUNT_WIDTH-1:0] rd_rem;
	logic [COUNT_WIDTH-1:0] rd_timeout;
	logic [COUNT_WIDTH-1:0] rem_dec;
	logic [COUNT_WIDTH-1:0] next_rem;
	logic                   next_active;
	dec_res_t               res;
	logic                   is_transport;

	logic              in_acc;
	logic              src_ok;
	logic [IDX_W-1:0]  src_idx;
	logic              can_push;
	logic              has_event;
	logic              advance;
	logic              load_pend;
	logic              push;
	logic              push_last;
	logic              pend_after;
	logic [KIND_W-1:0] new_kind;

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid & in_ready;
	assign src_ok   = (int'(source) < NUM_SOURCES);
	assign src_idx  = IDX_W'(source);
	assign can_push = ~out_valid_q | out_ready;

	// Idle uses the store for start/stop at the word's source; scan walks idx_q.
	assign ch_addr      = (state_q == ST_IDLE) ? src_idx : idx_q;
	assign is_transport = (int'(idx_q) == TRANSPORT_SRC);
	assign has_event    = res.bite | res.notice | res.bark;

	always_comb begin
		if (res.notice) begin
			new_kind = KIND_NOTICE;
		end else if (res.bite) begin
			new_kind = KIND_BITE;
		end else begin
			new_kind = KIND_BARK;
		end
	end

	mbbw_chan #(
		.NUM_SOURCES (NUM_SOURCES),
		.COUNT_WIDTH (COUNT_WIDTH),
		.IDX_W       (IDX_W)
	) u_chan (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata),
		.op         (ch_op),
		.addr       (ch_addr),
		.wr_rem     (next_rem),
		.wr_active  (next_active),
		.rd_active  (rd_active),
		.rd_rem     (rd_rem),
		.rd_timeout (rd_timeout)
	);

	mbbw_dec #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dec (
		.rem          (rd_rem),
		.timeout      (rd_timeout),
		.is_transport (is_transport),
		.rem_dec      (rem_dec),
		.next_rem     (next_rem),
		.next_active  (next_active),
		.res          (res)
	);

	// Sequencer decisions for this cycle.
	always_comb begin
		ch_op     = CH_NONE;
		advance   = 1'b0;
		load_pend = 1'b0;
		push      = 1'b0;
		push_last = 1'b0;
		case (state_q)
			ST_IDLE: begin
				// Apply start and stop straight to the store.
				if (in_acc && src_ok) begin
					if (command == CMD_START) begin
						ch_op = CH_START;
					end else if (command == CMD_STOP) begin
						ch_op = CH_STOP;
					end
				end
			end
			ST_SCAN: begin
				if (!rd_active) begin
					advance = 1'b1;
				end else if (!has_event) begin
					ch_op   = CH_UPDATE;
					advance = 1'b1;
				end else if (!pend_valid_q || can_push) begin
					// Release the held event and hold the new one.
					ch_op     = CH_UPDATE;
					advance   = 1'b1;
					load_pend = 1'b1;
					push      = pend_valid_q;
				end
				// else stall: output full and an event is already held
			end
			ST_FLUSH: begin
				if (can_push) begin
					push      = 1'b1;
					push_last = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign pend_after = pend_valid_q | load_pend;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			paused_q     <= 1'b0;
			pend_valid_q <= 1'b0;
			pend_src_q   <= '0;
			pend_kind_q  <= '0;
			pend_rem_q   <= '0;
			out_valid_q  <= 1'b0;
			out_src_q    <= '0;
			out_kind_q   <= '0;
			out_rem_q    <= '0;
			out_last_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (command)
							CMD_PAUSE: paused_q <= 1'b1;
							CMD_RESUME: paused_q <= 1'b0;
							CMD_TICK: begin
								if (!paused_q) begin
									idx_q   <= '0;
									state_q <= ST_SCAN;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (advance) begin
						if (idx_q == LAST_IDX) begin
							state_q <= pend_after ? ST_FLUSH : ST_IDLE;
						end else begin
							idx_q <= idx_q + IDX_W'(1);
						end
					end
				end
				ST_FLUSH: begin
					if (push_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (load_pend) begin
				pend_valid_q <= 1'b1;
			end else if (push_last) begin
				pend_valid_q <= 1'b0;
			end

			if (push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			// Capture the new event as held and advance the held one to the output.
			if (load_pend) begin
				pend_src_q  <= SRC_W'(idx_q);
				pend_kind_q <= new_kind;
				pend_rem_q  <= res.bark ? OUT_REM_W'(rem_dec) : '0;
			end
			if (push) begin
				out_src_q  <= pend_src_q;
				out_kind_q <= pend_kind_q;
				out_rem_q  <= pend_rem_q;
				out_last_q <= push_last;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign event_source    = out_src_q;
	assign event_kind      = out_kind_q;
	assign remaining_ticks = out_rem_q;
	assign last_event      = out_last_q;

endmodule

@@ rtl/mbbw_dec.sv @@
module mbbw_dec #(
	parameter int COUNT_WIDTH = mbbw_pkg::COUNT_WIDTH_DEF
) (
	input  logic [COUNT_WIDTH-1:0] rem,
	input  logic [COUNT_WIDTH-1:0] timeout,
	input  logic                   is_transport,
	output logic [COUNT_WIDTH-1:0] rem_dec,
	output logic [COUNT_WIDTH-1:0] next_rem,
	output logic                   next_active,
	output mbbw_pkg::dec_res_t     res
);
	import mbbw_pkg::*;

	logic zero;

	// Saturating decrement, then compare against half the timeout.
	assign rem_dec = (rem == '0) ? '0 : rem - COUNT_WIDTH'(1);
	assign zero    = (rem_dec == '0);

	assign res.bite   = zero & ~is_transport;
	assign res.notice = zero & is_transport;
	assign res.bark   = ~zero & ~is_transport & (rem_dec <= (timeout >> 1));

	// Transport reloads, other bites clear the channel.
	always_comb begin
		if (res.notice) begin
			next_rem    = timeout;
			next_active = 1'b1;
		end else if (res.bite) begin
			next_rem    = '0;
			next_active = 1'b0;
		end else begin
			next_rem    = rem_dec;
			next_active = 1'b1;
		end
	end

endmodule

@@ rtl/mbbw_chan.sv @@
module mbbw_chan #(
	parameter int NUM_SOURCES = mbbw_pkg::NUM_SOURCES_DEF,
	parameter int COUNT_WIDTH = mbbw_pkg::COUNT_WIDTH_DEF,
	parameter int IDX_W       = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [mbbw_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [mbbw_pkg::REG_W-1:0]       cfg_wdata,
	input  mbbw_pkg::chan_op_t               op,
	input  logic [IDX_W-1:0]                 addr,
	input  logic [COUNT_WIDTH-1:0]           wr_rem,
	input  logic                             wr_active,
	output logic                             rd_active,
	output logic [COUNT_WIDTH-1:0]           rd_rem,
	output logic [COUNT_WIDTH-1:0]           rd_timeout
);
	import mbbw_pkg::*;

	logic [REG_W-1:0]       timeout_q [NUM_REGS];
	logic                   active_q  [NUM_SOURCES];
	logic [COUNT_WIDTH-1:0] remain_q  [NUM_SOURCES];

	// Channels past the register list have a zero timeout.
	assign rd_timeout = (int'(addr) < NUM_REGS) ?
		COUNT_WIDTH'(timeout_q[CFG_IDX_W'(addr)]) : '0;
	assign rd_active  = active_q[addr];
	assign rd_rem     = remain_q[addr];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				timeout_q[i] <= REG_RESET[i];
			end
		end else if (cfg_wr_en && (int'(cfg_idx) < NUM_REGS)) begin
			timeout_q[cfg_idx] <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SOURCES; i++) begin
				active_q[i] <= 1'b0;
				remain_q[i] <= '0;
			end
		end else begin
			case (op)
				CH_START: begin
					active_q[addr] <= 1'b1;
					remain_q[addr] <= rd_timeout;
				end
				CH_STOP: begin
					active_q[addr] <= 1'b0;
					remain_q[addr] <= '0;
				end
				CH_UPDATE: begin
					active_q[addr] <= wr_active;
					remain_q[addr] <= wr_rem;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

@@ rtl/mbbw_checker.sv @@
`include "multi_source_bark_bite_watchdog_assert.svh"

module mbbw_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic [mbbw_pkg::CMD_W-1:0]       command,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [mbbw_pkg::SRC_W-1:0]       event_source,
	input logic [mbbw_pkg::KIND_W-1:0]      event_kind,
	input logic [mbbw_pkg::OUT_REM_W-1:0]   remaining_ticks,
	input logic                             last_event
);
	import mbbw_pkg::*;

	// A stalled event word holds.
	`MBBW_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(event_source) && $stable(event_kind) && $stable(remaining_ticks) && $stable(last_event))

	// Only the transport channel reloads, and it reports a zero count.
	`MBBW_ASSERT_IMPL(a_notice_src, clk, arst_n, out_valid && event_kind == KIND_NOTICE, event_source == SRC_W'(TRANSPORT_SRC) && remaining_ticks == '0)

	// A fatal bite reports a zero count and never comes from transport.
	`MBBW_ASSERT_IMPL(a_bite_zero, clk, arst_n, out_valid && event_kind == KIND_BITE, remaining_ticks == '0 && event_source != SRC_W'(TRANSPORT_SRC))

	// While a tick still has events to deliver, no new word is taken.
	`MBBW_ASSERT_IMPL(a_busy_mid_tick, clk, arst_n, out_valid && !last_event, !in_ready)

	// A start word never blocks the command side.
	`MBBW_ASSERT_NEXT(a_start_quick, clk, arst_n, in_valid && in_ready && command == CMD_START, in_ready)

endmodule

bind multi_source_bark_bite_watchdog mbbw_checker u_mbbw_checker (.*);

@@ sim/tb.sv @@
module tb;
	import mbbw_pkg::*;

	// Largest codes the command and source fields can carry; anything above
	// CMD_TICK or at NUM_SOURCES_DEF and up must be ignored by the block.
	localparam int CMD_MAX = (1 << CMD_W) - 1;
	localparam int SRC_MAX = (1 << SRC_W) - 1;
	localparam int NUM_CH  = NUM_SOURCES_DEF;

	// A tick word scans all channels and may flush a held event; leave margin on top.
	localparam int SETTLE_CYCLES = 3 * (NUM_CH + 2);
	localparam int DRAIN_LIMIT   = 4000;
	localparam int PHASE_WORDS   = 67;
	localparam int NUM_PHASES    = 5;

	typedef struct packed {
		logic [SRC_W-1:0]     src;
		logic [KIND_W-1:0]    kind;
		logic [OUT_REM_W-1:0] rem;
		logic                 last;
	} wd_event_t;

	// Scoreboard: mirrors the channel store and holds the events still owed.
	class wdog_scoreboard;
		logic [REG_W-1:0]       timeout_ticks [NUM_REGS];
		bit                     channel_armed [NUM_CH];
		logic [COUNT_WIDTH_DEF-1:0] ticks_left [NUM_CH];
		bit                     frozen;
		wd_event_t              due_events [$];
		int                     error_count;

		function new();
			foreach (timeout_ticks[i]) timeout_ticks[i] = REG_RESET[i];
			foreach (channel_armed[i]) begin
				channel_armed[i] = 1'b0;
				ticks_left[i] = '0;
			end
			frozen = 1'b0;
			error_count = 0;
		endfunction

		function void set_timeout(int idx, logic [REG_W-1:0] val);
			if (idx < NUM_REGS) timeout_ticks[idx] = val;
		endfunction

		// One tick: decrement every armed channel in source order.
		function void count_down();
			wd_event_t found [$];
			logic [COUNT_WIDTH_DEF-1:0] left;
			for (int i = 0; i < NUM_CH; i++) begin
				if (!channel_armed[i]) continue;
				left = ticks_left[i];
				if (left != 0) left = left - 1'b1;
				ticks_left[i] = left;
				if (left == 0) begin
					if (i == TRANSPORT_SRC) begin
						found.push_back('{SRC_W'(i), KIND_NOTICE, '0, 1'b0});
						ticks_left[i] = timeout_ticks[i];
					end else begin
						found.push_back('{SRC_W'(i), KIND_BITE, '0, 1'b0});
						channel_armed[i] = 1'b0;
						ticks_left[i] = '0;
					end
				end else if (i != TRANSPORT_SRC && left <= (timeout_ticks[i] >> 1)) begin
					found.push_back('{SRC_W'(i), KIND_BARK, OUT_REM_W'(left), 1'b0});
				end
			end
			if (found.size() != 0) found[found.size() - 1].last = 1'b1;
			foreach (found[k]) due_events.push_back(found[k]);
		endfunction

		function void note_command(logic [CMD_W-1:0] cmd, logic [SRC_W-1:0] src);
			case (cmd)
				CMD_START: begin
					if (src < NUM_CH) begin
						channel_armed[src] = 1'b1;
						ticks_left[src] = (src < NUM_REGS) ? timeout_ticks[src] : '0;
					end
				end
				CMD_STOP: begin
					if (src < NUM_CH) begin
						channel_armed[src] = 1'b0;
						ticks_left[src] = '0;
					end
				end
				CMD_PAUSE:  frozen = 1'b1;
				CMD_RESUME: frozen = 1'b0;
				CMD_TICK: begin
					if (!frozen) count_down();
				end
				default: ;
			endcase
		endfunction

		function void check_event(wd_event_t got);
			wd_event_t want;
			if (due_events.size() == 0) begin
				$display("%0t: unexpected event src=%0d kind=%0d rem=%0d last=%0d",
					$time, got.src, got.kind, got.rem, got.last);
				error_count++;
				return;
			end
			want = due_events.pop_front();
			if (got !== want) begin
				$display("%0t: event mismatch: expected src=%0d kind=%0d rem=%0d last=%0d, actual src=%0d kind=%0d rem=%0d last=%0d",
					$time, want.src, want.kind, want.rem, want.last,
					got.src, got.kind, got.rem, got.last);
				error_count++;
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [REG_W-1:0]     cfg_wdata = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [CMD_W-1:0]     command = '0;
	logic [SRC_W-1:0]     source = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [SRC_W-1:0]     event_source;
	logic [KIND_W-1:0]    event_kind;
	logic [OUT_REM_W-1:0] remaining_ticks;
	logic                 last_event;

	// One idle burst starts on roughly one cycle in idle_odds; zero means no idling.
	int idle_odds = 0;

	wdog_scoreboard sb = new();

	multi_source_bark_bite_watchdog dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_idx        (cfg_idx),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.command        (command),
		.source         (source),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.event_source   (event_source),
		.event_kind     (event_kind),
		.remaining_ticks(remaining_ticks),
		.last_event     (last_event)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Hard stop in case the block hangs on either handshake.
	initial begin
		#2000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Event side: sample at the edge (pre-edge values), then pick the next ready.
	initial begin
		int stall_left;
		stall_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_ready === 1'b1)
				sb.check_event('{event_source, event_kind, remaining_ticks, last_event});
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
				// start a burst of stalled cycles, this one included
				stall_left = $urandom_range(0, 14);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Present one command word and hold it until the block takes it.
	// Call only right after a rising edge.
	task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [SRC_W-1:0] src);
		int gap;
		gap = (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) ? $urandom_range(1, 15) : 0;
		if (gap > 0) begin
			// drop valid for the gap; back-to-back words keep it high
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command  <= cmd;
		source   <= src;
		do @(posedge clk); while (in_ready !== 1'b1);
		sb.note_command(cmd, src);
	endtask

	// Write all timeout registers back to back, then poke the unused index.
	task automatic program_timeouts(input logic [REG_W-1:0] vals [NUM_REGS]);
		for (int i = 0; i < NUM_REGS; i++) begin
			cfg_wr_en <= 1'b1;
			cfg_idx   <= CFG_IDX_W'(i);
			cfg_wdata <= vals[i];
			@(posedge clk);
			sb.set_timeout(i, vals[i]);
		end
		// index past the register list must not disturb anything
		cfg_wr_en <= 1'b1;
		cfg_idx   <= CFG_IDX_W'(NUM_REGS);
		cfg_wdata <= REG_W'($urandom);
		@(posedge clk);
		sb.set_timeout(NUM_REGS, cfg_wdata);
		cfg_wr_en <= 1'b0;
	endtask

	// Wait for every owed event, then let a silent tick finish its scan.
	task automatic drain();
		int waited;
		in_valid <= 1'b0;
		waited = 0;
		while (sb.due_events.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (sb.due_events.size() != 0) begin
			$display("%0t: %0d expected events never arrived, next expected src=%0d kind=%0d",
				$time, sb.due_events.size(), sb.due_events[0].src, sb.due_events[0].kind);
			sb.error_count++;
			sb.due_events.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Directed opening at the reset timeouts: arm every channel (plus an
	// out-of-range source), tick, pause over ticks, unknown commands, stop,
	// re-arm an active channel and tick on past the bite of channel 3.
	task automatic directed_words();
		for (int s = 0; s <= SRC_MAX; s++) send_word(CMD_START, SRC_W'(s));
		repeat (3) send_word(CMD_TICK, '0);
		send_word(CMD_PAUSE, '0);
		send_word(CMD_TICK, '0);
		send_word(CMD_TICK, SRC_W'(TRANSPORT_SRC));
		send_word(CMD_RESUME, '0);
		for (int c = int'(CMD_TICK) + 1; c <= CMD_MAX; c++)
			send_word(CMD_W'(c), SRC_W'(c));
		send_word(CMD_STOP, SRC_W'(1));
		send_word(CMD_STOP, SRC_W'(SRC_MAX));
		send_word(CMD_START, '0);
		repeat (4) send_word(CMD_TICK, SRC_W'(SRC_MAX));
	endtask

	// Random words, weighted toward ticks and starts so channels run down
	// to barks and bites; stops, pause/resume and junk codes are the noise.
	task automatic random_words(input int count);
		int roll;
		logic [CMD_W-1:0] cmd;
		logic [SRC_W-1:0] src;
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(0, 99);
			if (roll < 44)      cmd = CMD_TICK;
			else if (roll < 74) cmd = CMD_START;
			else if (roll < 82) cmd = CMD_STOP;
			else if (roll < 86) cmd = CMD_PAUSE;
			else if (roll < 93) cmd = CMD_RESUME;
			else                cmd = CMD_W'($urandom_range(int'(CMD_TICK) + 1, CMD_MAX));
			// out-of-range source now and then
			if ($urandom_range(0, 19) == 0) src = SRC_W'($urandom_range(NUM_CH, SRC_MAX));
			else                            src = SRC_W'($urandom_range(0, NUM_CH - 1));
			send_word(cmd, src);
		end
	endtask

	initial begin
		logic [REG_W-1:0] setting [NUM_REGS];

		// hold reset, then release it on an edge
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_odds = 4;
		directed_words();
		drain();

		for (int p = 1; p <= NUM_PHASES; p++) begin
			case (p)
				1: begin
					// timeouts of one: every armed channel bites or reloads each tick
					foreach (setting[i]) setting[i] = 16'd1;
					idle_odds = 6;
				end
				2: begin
					foreach (setting[i]) setting[i] = REG_W'($urandom_range(1, 12));
					idle_odds = 0;
				end
				3: begin
					// zero loads bite on the next tick, or notice on transport; the maximum never runs out here
					setting = '{16'd0, 16'hFFFF, 16'd3, 16'hFFFF, 16'd0, 16'd7, 16'd2};
					idle_odds = 2;
				end
				4: begin
					foreach (setting[i]) setting[i] = REG_W'($urandom_range(2, 40));
					idle_odds = 5;
				end
				default: begin
					// final stretch runs with no idling on either side
					foreach (setting[i]) setting[i] = REG_W'($urandom_range(1, 10));
					idle_odds = 0;
				end
			endcase
			program_timeouts(setting);
			random_words(PHASE_WORDS);
			drain();
		end

		if (sb.error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

@@ multi_source_bark_bite_watchdog.f @@
+incdir+rtl
rtl/mbbw_pkg.sv
rtl/mbbw_dec.sv
rtl/mbbw_chan.sv
rtl/multi_source_bark_bite_watchdog.sv
rtl/mbbw_checker.sv
sim/tb.sv
